@@ sv/rcmix_pkg.sv @@
// Shared constants, codes and controller/datapath types for the RC pulse mixer.
package rcmix_pkg;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 20;

    // Duty ratio limits in Q0.20.
    localparam logic [16:0] DMIN      = 17'd52429;
    localparam logic [16:0] DMAX      = 17'd104858;
    localparam logic [16:0] DMID      = 17'd78643;
    localparam logic [15:0] DSPAN     = 16'd52429;
    localparam logic [15:0] UP_SPAN   = 16'd26215;  // DMAX - DMID
    localparam logic [15:0] DN_SPAN   = 16'd26214;  // DMID - DMIN
    localparam logic [31:0] HALF_SPAN = 32'd26214;  // rounding term of the 16-bit map

    localparam logic [15:0] THROTTLE_RESET = 16'h7fff;

    localparam logic [5:0] DUTY_STEPS = 6'd17;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] REG_NORMAL_GAIN  = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_BOOSTED_GAIN = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_HIGH_GAIN    = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_BRAKE_GAIN   = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_KNEE         = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_SPEED_LIMIT  = 3'd5;

    typedef enum logic [1:0] {
        CH_THROTTLE = 2'd0,
        CH_STEER    = 2'd1,
        CH_LIMITER  = 2'd2,
        CH_BOOST    = 2'd3
    } chan_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_START,
        S_DIV_DUTY,
        S_CLAMP,
        S_GAIN,
        S_SCALE,
        S_MAP_LOAD,
        S_MAP_MUL,
        S_MAP_FIX,
        S_APPLY
    } state_t;

    typedef struct packed {
        logic capture;
        logic duty_load;
        logic div_step;
        logic clamp;
        logic gain;
        logic scale;
        logic map_load;
        logic map_mul;
        logic map_fix;
        logic apply;
    } cmd_t;

    typedef struct packed {
        logic period_zero;
        logic div_busy;
        logic switch_chan;
        logic out_free;
    } stat_t;

endpackage

@@ sv/rc_pwm_throttle_steer_mixer_unit.sv @@
// Top level of the RC pulse mixer: throttle curve, steering map, limiter and boost switches.
//
//   channel   direction  handshake             payload
//   input     in         in_valid / in_stall   channel, high_time, pulse_period
//   output    out        out_valid / out_stall steer_valid, steer_value,
//                                              throttle_valid, throttle_value
//   config    in         cfg_we                cfg_index, cfg_data (no read-back)
//
// Every accepted word yields exactly one output word. The duty ratio comes from
// a 1-bit-per-cycle restoring divider (17 steps); throttle and steering words
// then pass the gain multiply and the 16-bit map (load, multiply and fix-up),
// while the limiter and boost switches, and any word with a zero period, go
// straight to the write-out. The block takes the next word after the write-out.
// Reset (rst_n low, asynchronous) restores the register defaults, the throttle
// command 0x7fff and clears both switches. A stalled output word holds while the
// next input word is already being worked on; only the final write-out waits.
module rc_pwm_throttle_steer_mixer_unit
    import rcmix_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic [1:0]             channel,
    input  logic [23:0]            high_time,
    input  logic [23:0]            pulse_period,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic                   steer_valid,
    output logic [15:0]            steer_value,
    output logic                   throttle_valid,
    output logic [15:0]            throttle_value
);

    cmd_t  cmd;
    stat_t stat;

    // sequencer: one word at a time, advance on datapath status
    rcmix_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    // datapath: divider, gain multiply, curve, limiter and output word
    rcmix_dp u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .stat           (stat),
        .channel        (channel),
        .high_time      (high_time),
        .pulse_period   (pulse_period),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .steer_valid    (steer_valid),
        .steer_value    (steer_value),
        .throttle_valid (throttle_valid),
        .throttle_value (throttle_value)
    );

    // after taking a word the block is busy in the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input taken twice in a row");

    // the sequencer issues at most one datapath command per cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(cmd))
        else $error("overlapping datapath commands");

    // a word without a steering update carries a zero steering value
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !steer_valid |-> steer_value == 16'd0)
        else $error("stale steering value");

    // the final write-out never overruns a stalled output word
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.apply |-> !(out_valid && out_stall))
        else $error("output word overwritten while stalled");

endmodule

@@ sv/rcmix_ctrl.sv @@
// Sequencer for the mixer: steps the datapath through divide, curve, map and write-out.
module rcmix_ctrl
    import rcmix_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_stall,
    input  stat_t stat,
    output cmd_t  cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_stall   = 1'b1;
        case (state_reg)
            S_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_START;
                end
            end
            S_START:
            begin
                if (stat.period_zero)
                begin
                    state_next = S_APPLY;
                end
                else
                begin
                    cmd.duty_load = 1'b1;
                    state_next    = S_DIV_DUTY;
                end
            end
            S_DIV_DUTY:
            begin
                if (stat.div_busy)
                begin
                    cmd.div_step = 1'b1;
                end
                else
                begin
                    state_next = S_CLAMP;
                end
            end
            S_CLAMP:
            begin
                cmd.clamp  = 1'b1;
                state_next = stat.switch_chan ? S_APPLY : S_GAIN;
            end
            S_GAIN:
            begin
                cmd.gain   = 1'b1;
                state_next = S_SCALE;
            end
            S_SCALE:
            begin
                cmd.scale  = 1'b1;
                state_next = S_MAP_LOAD;
            end
            S_MAP_LOAD:
            begin
                cmd.map_load = 1'b1;
                state_next   = S_MAP_MUL;
            end
            S_MAP_MUL:
            begin
                cmd.map_mul = 1'b1;
                state_next  = S_MAP_FIX;
            end
            S_MAP_FIX:
            begin
                cmd.map_fix = 1'b1;
                state_next  = S_APPLY;
            end
            S_APPLY:
            begin
                // hold until the output register can take the word
                if (stat.out_free)
                begin
                    cmd.apply  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

@@ sv/rcmix_dp.sv @@
// Mixer datapath: duty-ratio divider, gain multiplier, 16-bit map, config and output registers.
module rcmix_dp
    import rcmix_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  cmd_t                   cmd,
    output stat_t                  stat,
    input  logic [1:0]             channel,
    input  logic [23:0]            high_time,
    input  logic [23:0]            pulse_period,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic                   steer_valid,
    output logic [15:0]            steer_value,
    output logic                   throttle_valid,
    output logic [15:0]            throttle_value
);

    // configuration
    logic [16:0] normal_gain_reg,  normal_gain_next;
    logic [16:0] boosted_gain_reg, boosted_gain_next;
    logic [16:0] high_gain_reg,    high_gain_next;
    logic [16:0] brake_gain_reg,   brake_gain_next;
    logic [19:0] knee_reg,         knee_next;
    logic [15:0] speed_limit_reg,  speed_limit_next;

    // mixer state
    logic [15:0] throttle_now_reg,     throttle_now_next;
    logic [15:0] throttle_written_reg, throttle_written_next;
    logic        limiter_on_reg,       limiter_on_next;
    logic        boost_on_reg,         boost_on_next;

    // item and working registers
    chan_t       channel_reg, channel_next;
    logic [23:0] high_reg,    high_next;
    logic [23:0] period_reg,  period_next;
    logic        sat_reg,     sat_next;
    logic [23:0] rem_reg,     rem_next;
    logic [31:0] dvd_reg,     dvd_next;
    logic [31:0] quo_reg,     quo_next;
    logic [23:0] divisor_reg, divisor_next;
    logic [5:0]  cnt_reg,     cnt_next;
    logic [16:0] c_reg,       c_next;
    logic [31:0] prod_reg,    prod_next;
    logic [15:0] n_reg,       n_next;

    // output word
    logic        out_valid_reg,      out_valid_next;
    logic        steer_valid_reg,    steer_valid_next;
    logic [15:0] steer_value_reg,    steer_value_next;
    logic        throttle_valid_reg, throttle_valid_next;
    logic [15:0] throttle_value_reg, throttle_value_next;

    // combinational helpers
    logic [24:0] div_trial;
    logic [24:0] div_diff;
    logic        div_ge;
    logic [16:0] quo_duty;
    logic        duty_gt_mid;
    logic        duty_ge_mid;
    logic [16:0] duty_clamped;
    logic        curve_up;
    logic [16:0] excess;
    logic [14:0] excess_narrow;
    logic [16:0] gain_sel;
    logic [15:0] scaled;
    logic [15:0] n_curve;
    logic        work_ok;
    logic [15:0] throttle_cand;
    logic [15:0] throttle_lim;
    logic [16:0] map_est;
    logic [32:0] map_lo;
    logic [32:0] map_hi;
    logic        map_over_hi;
    logic        map_over_lo;

    assign stat.period_zero = (period_reg == 24'd0);
    assign stat.div_busy    = (cnt_reg != 6'd0);
    assign stat.switch_chan = channel_reg inside {CH_LIMITER, CH_BOOST};
    assign stat.out_free    = !out_valid_reg || !out_stall;

    // one quotient bit per step; unless the ratio saturates, the remainder stays below the divisor
    assign div_trial = {rem_reg, dvd_reg[31]};
    assign div_diff  = div_trial - {1'b0, divisor_reg};
    assign div_ge    = (div_trial >= {1'b0, divisor_reg});

    // duty ratio: saturation covers every quotient of 2^17 and above
    assign quo_duty     = quo_reg[16:0];
    assign duty_gt_mid  = sat_reg || (quo_duty > DMID);
    assign duty_ge_mid  = sat_reg || (quo_duty >= DMID);
    assign duty_clamped = sat_reg ? DMAX :
                          (quo_duty < DMIN) ? DMIN :
                          (quo_duty > DMAX) ? DMAX : quo_duty;

    // throttle curve
    assign curve_up      = (c_reg >= DMID);
    assign excess        = curve_up ? (c_reg - DMID) : (DMID - c_reg);
    assign excess_narrow = excess[14:0];

    always_comb
    begin
        if (!curve_up)
        begin
            gain_sel = brake_gain_reg;
        end
        else if ({3'b000, excess} > knee_reg)
        begin
            gain_sel = high_gain_reg;
        end
        else if (boost_on_reg)
        begin
            gain_sel = boosted_gain_reg;
        end
        else
        begin
            gain_sel = normal_gain_reg;
        end
    end

    assign scaled = prod_reg[31:16];

    // offset from DMIN of the curved duty, clamped to the span
    always_comb
    begin
        if (curve_up)
        begin
            n_curve = (scaled > UP_SPAN) ? DSPAN : (DN_SPAN + scaled);
        end
        else
        begin
            n_curve = (scaled > DN_SPAN) ? 16'd0 : (DN_SPAN - scaled);
        end
    end

    // 16-bit map by the constant span: 65535/DSPAN is just under 5/4, so
    // floor(5n/4) lands within one of the rounded quotient; two compares fix it
    assign map_est     = {1'b0, n_reg} + {3'b000, n_reg[15:2]};
    assign map_lo      = {1'b0, prod_reg};
    assign map_hi      = {1'b0, prod_reg} + {17'd0, DSPAN};
    assign map_over_hi = ({1'b0, dvd_reg} < map_hi);
    assign map_over_lo = ({1'b0, dvd_reg} < map_lo);

    assign work_ok       = !stat.period_zero;
    assign throttle_cand = (work_ok && channel_reg == CH_THROTTLE) ? quo_reg[15:0]
                                                                   : throttle_now_reg;
    assign throttle_lim  = (limiter_on_reg && throttle_cand > speed_limit_reg) ?
                           speed_limit_reg : throttle_cand;

    always_comb
    begin
        normal_gain_next      = normal_gain_reg;
        boosted_gain_next     = boosted_gain_reg;
        high_gain_next        = high_gain_reg;
        brake_gain_next       = brake_gain_reg;
        knee_next             = knee_reg;
        speed_limit_next      = speed_limit_reg;
        throttle_now_next     = throttle_now_reg;
        throttle_written_next = throttle_written_reg;
        limiter_on_next       = limiter_on_reg;
        boost_on_next         = boost_on_reg;
        channel_next          = channel_reg;
        high_next             = high_reg;
        period_next           = period_reg;
        sat_next              = sat_reg;
        rem_next              = rem_reg;
        dvd_next              = dvd_reg;
        quo_next              = quo_reg;
        divisor_next          = divisor_reg;
        cnt_next              = cnt_reg;
        c_next                = c_reg;
        prod_next             = prod_reg;
        n_next                = n_reg;
        out_valid_next        = out_valid_reg && out_stall;
        steer_valid_next      = steer_valid_reg;
        steer_value_next      = steer_value_reg;
        throttle_valid_next   = throttle_valid_reg;
        throttle_value_next   = throttle_value_reg;

        if (cfg_we)
        begin
            case (cfg_index)
                REG_NORMAL_GAIN:  normal_gain_next  = cfg_data[16:0];
                REG_BOOSTED_GAIN: boosted_gain_next = cfg_data[16:0];
                REG_HIGH_GAIN:    high_gain_next    = cfg_data[16:0];
                REG_BRAKE_GAIN:   brake_gain_next   = cfg_data[16:0];
                REG_KNEE:         knee_next         = cfg_data[19:0];
                REG_SPEED_LIMIT:  speed_limit_next  = cfg_data[15:0];
                default:          ;
            endcase
        end

        if (cmd.capture)
        begin
            channel_next = chan_t'(channel);
            high_next    = high_time;
            period_next  = pulse_period;
        end

        if (cmd.duty_load)
        begin
            // quotient of 2^17 or more iff high*8 >= period; otherwise only
            // the low 17 quotient bits remain, starting from high*8
            sat_next     = ({high_reg, 3'b000} >= {3'b000, period_reg});
            rem_next     = {high_reg[20:0], 3'b000};
            dvd_next     = 32'd0;
            quo_next     = 32'd0;
            divisor_next = period_reg;
            cnt_next     = DUTY_STEPS;
        end

        if (cmd.map_load)
        begin
            dvd_next = {n_reg, 16'd0} - {16'd0, n_reg} + HALF_SPAN;
            quo_next = {15'd0, map_est};
        end

        if (cmd.map_mul)
        begin
            prod_next = {15'd0, quo_reg[16:0]} * {16'd0, DSPAN};
        end

        if (cmd.map_fix)
        begin
            quo_next = quo_reg + 32'd1 - {31'd0, map_over_hi} - {31'd0, map_over_lo};
        end

        if (cmd.div_step)
        begin
            rem_next = div_ge ? div_diff[23:0] : div_trial[23:0];
            dvd_next = {dvd_reg[30:0], 1'b0};
            quo_next = {quo_reg[30:0], div_ge};
            cnt_next = cnt_reg - 6'd1;
        end

        if (cmd.clamp)
        begin
            c_next = duty_clamped;
            case (channel_reg)
                CH_LIMITER: limiter_on_next = duty_gt_mid;
                CH_BOOST:   boost_on_next   = duty_ge_mid;
                default:    ;
            endcase
        end

        if (cmd.gain)
        begin
            prod_next = {15'd0, gain_sel} * {17'd0, excess_narrow};
        end

        if (cmd.scale)
        begin
            n_next = (channel_reg == CH_THROTTLE) ? n_curve : 16'(c_reg - DMIN);
        end

        if (cmd.apply)
        begin
            throttle_now_next     = throttle_lim;
            throttle_written_next = throttle_lim;
            out_valid_next        = 1'b1;
            steer_valid_next      = work_ok && (channel_reg == CH_STEER);
            steer_value_next      = (work_ok && channel_reg == CH_STEER) ? ~quo_reg[15:0]
                                                                         : 16'd0;
            throttle_valid_next   = (throttle_lim != throttle_written_reg);
            throttle_value_next   = throttle_lim;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            normal_gain_reg      <= 17'd9830;
            boosted_gain_reg     <= 17'd14746;
            high_gain_reg        <= 17'd13763;
            brake_gain_reg       <= 17'd39322;
            knee_reg             <= 20'd91750;
            speed_limit_reg      <= 16'hffff;
            throttle_now_reg     <= THROTTLE_RESET;
            throttle_written_reg <= THROTTLE_RESET;
            limiter_on_reg       <= 1'b0;
            boost_on_reg         <= 1'b0;
            cnt_reg              <= 6'd0;
            out_valid_reg        <= 1'b0;
        end
        else
        begin
            normal_gain_reg      <= normal_gain_next;
            boosted_gain_reg     <= boosted_gain_next;
            high_gain_reg        <= high_gain_next;
            brake_gain_reg       <= brake_gain_next;
            knee_reg             <= knee_next;
            speed_limit_reg      <= speed_limit_next;
            throttle_now_reg     <= throttle_now_next;
            throttle_written_reg <= throttle_written_next;
            limiter_on_reg       <= limiter_on_next;
            boost_on_reg         <= boost_on_next;
            cnt_reg              <= cnt_next;
            out_valid_reg        <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        channel_reg        <= channel_next;
        high_reg           <= high_next;
        period_reg         <= period_next;
        sat_reg            <= sat_next;
        rem_reg            <= rem_next;
        dvd_reg            <= dvd_next;
        quo_reg            <= quo_next;
        divisor_reg        <= divisor_next;
        c_reg              <= c_next;
        prod_reg           <= prod_next;
        n_reg              <= n_next;
        steer_valid_reg    <= steer_valid_next;
        steer_value_reg    <= steer_value_next;
        throttle_valid_reg <= throttle_valid_next;
        throttle_value_reg <= throttle_value_next;
    end

    assign out_valid      = out_valid_reg;
    assign steer_valid    = steer_valid_reg;
    assign steer_value    = steer_value_reg;
    assign throttle_valid = throttle_valid_reg;
    assign throttle_value = throttle_value_reg;

endmodule
